@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, idle during reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/mts_pkg.sv @@
`timescale 1ns / 1ps
package mts_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic empty;
		logic is_full;
		logic [1:0] status;
	} result_t;

endpackage

@@ rtl/mts_ram.sv @@
`timescale 1ns / 1ps
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/mts_core.sv @@
`timescale 1ns / 1ps
module mts_core import mts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] value,
	output result_t                  result
);

	// Stack counts and cached tops
	logic [CNT_W-1:0]         fill_q, fill_n;
	logic [CNT_W-1:0]         mcount_q, mcount_n;
	logic signed [DATA_W-1:0] top_q, top_n;
	logic signed [DATA_W-1:0] mtop_q, mtop_n;

	// Memory ports
	logic              val_we, min_we;
	logic [IDX_W-1:0]  val_waddr, min_waddr;
	logic [IDX_W-1:0]  val_raddr, min_raddr;
	logic [DATA_W-1:0] val_rd, min_rd;

	logic signed [DATA_W-1:0] popped;
	logic [1:0]               status;

	// Entry below each top is read for the state after this cycle
	assign val_raddr = IDX_W'(fill_n - CNT_W'(2));
	assign min_raddr = IDX_W'(mcount_n - CNT_W'(2));
	assign val_waddr = fill_q[IDX_W-1:0];
	assign min_waddr = mcount_q[IDX_W-1:0];

	mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (value),
		.raddr (val_raddr),
		.rdata (val_rd)
	);

	mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (min_we),
		.waddr (min_waddr),
		.wdata (value),
		.raddr (min_raddr),
		.rdata (min_rd)
	);

	// Apply one push or pop to both stacks
	always_comb begin
		fill_n = fill_q;
		mcount_n = mcount_q;
		top_n = top_q;
		mtop_n = mtop_q;
		val_we = 1'b0;
		min_we = 1'b0;
		popped = '0;
		status = ST_OK;
		if (fire) begin
			if (op == OP_PUSH) begin
				if (fill_q == CNT_W'(DEPTH)) begin
					status = ST_OVERFLOW;
				end else begin
					val_we = 1'b1;
					fill_n = fill_q + CNT_W'(1);
					top_n = value;
					if (mcount_q != CNT_W'(DEPTH) &&
					    (mcount_q == '0 || value <= mtop_q)) begin
						min_we = 1'b1;
						mcount_n = mcount_q + CNT_W'(1);
						mtop_n = value;
					end
				end
			end else begin
				if (fill_q == '0) begin
					status = ST_UNDERFLOW;
				end else begin
					popped = top_q;
					fill_n = fill_q - CNT_W'(1);
					top_n = $signed(val_rd);
					if (mcount_q != '0 && mtop_q == top_q) begin
						mcount_n = mcount_q - CNT_W'(1);
						mtop_n = $signed(min_rd);
					end
				end
			end
		end
	end

	// Form the result from the state after the transfer
	always_comb begin
		result.popped_value = popped;
		result.top_value = (fill_n != '0) ? top_n : '0;
		result.min_value = (fill_n != '0 && mcount_n != '0) ? mtop_n : '0;
		result.empty = (fill_n == '0);
		result.is_full = (fill_n == CNT_W'(DEPTH));
		result.status = status;
	end

	// Hold counts under reset, advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			mcount_q <= '0;
		end else begin
			fill_q <= fill_n;
			mcount_q <= mcount_n;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_n;
		mtop_q <= mtop_n;
	end

endmodule

@@ rtl/min_tracking_stack_unit.sv @@
`timescale 1ns / 1ps
// Each transfer is held in the input register and its result in the result register.
// Throughput: one push or pop per cycle while out_stall does not hold the result register;
// the stack tops are held in registers with the entry below each prefetched from its RAM.
// Reset: arst_n clears both stack counts and the valid flags; stack RAMs are not cleared.
module min_tracking_stack_unit import mts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] popped_value,
	output logic signed [DATA_W-1:0] top_value,
	output logic signed [DATA_W-1:0] min_value,
	output logic                     empty,
	output logic                     is_full,
	output logic [1:0]               status
);

	logic                     valid_s1;
	logic                     op_s1;
	logic signed [DATA_W-1:0] value_s1;
	logic                     out_valid_q;
	result_t                  result_q;
	result_t                  result;
	logic                     advance;
	logic                     fire;

	// Advance when the result register is free or being drained
	assign advance = !out_valid_q || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			value_s1 <= value;
		end
	end

	mts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.value  (value_s1),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign popped_value = result_q.popped_value;
	assign top_value = result_q.top_value;
	assign min_value = result_q.min_value;
	assign empty = result_q.empty;
	assign is_full = result_q.is_full;
	assign status = result_q.status;

endmodule

@@ rtl/mts_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mts_checker import mts_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] popped_value,
	input logic signed [DATA_W-1:0] top_value,
	input logic signed [DATA_W-1:0] min_value,
	input logic                     empty,
	input logic                     is_full,
	input logic [1:0]               status
);

	logic out_wait;
	logic out_empty;
	logic out_ovf;
	logic out_unf;
	logic out_nonempty;

	// Qualify result conditions with out_valid
	assign out_wait = out_valid && out_stall;
	assign out_empty = out_valid && empty;
	assign out_ovf = out_valid && status == ST_OVERFLOW;
	assign out_unf = out_valid && status == ST_UNDERFLOW;
	assign out_nonempty = out_valid && !empty;

	// Stalled result holds
	`ASSERT_CLK(a_out_hold, out_wait |=> out_valid && $stable(top_value), "stalled result moved")
	// Empty stack reports zero top and minimum
	`ASSERT_CLK(a_empty_zero, out_empty |-> {top_value, min_value} == '0, "empty but nonzero")
	// Overflow only on a full stack
	`ASSERT_CLK(a_ovf_full, out_ovf |-> is_full && popped_value == '0, "overflow when not full")
	// Underflow only on an empty stack
	`ASSERT_CLK(a_unf_empty, out_unf |-> empty && popped_value == '0, "underflow when not empty")
	// Minimum never above top
	`ASSERT_NEVER(a_min_top, out_nonempty && min_value > top_value, "minimum above top")

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.popped_value (popped_value),
	.top_value    (top_value),
	.min_value    (min_value),
	.empty        (empty),
	.is_full      (is_full),
	.status       (status)
);
